FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DLF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define DLF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/dlf_pkg.sv
`default_nettype none
package dlf_pkg;

   localparam int NUM_SLOTS    = 8;
   localparam int NUM_CHANNELS = 16;
   localparam int IDX_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W        = $clog2(NUM_SLOTS + 1);
   localparam int NUM_W        = 40;
   localparam int DIV_STEPS    = 8;
   localparam int DCNT_W       = $clog2(DIV_STEPS);
   localparam logic [6:0] MS_PER_TENTH = 7'd100;

   typedef enum logic [1:0] {
      OP_LEVEL      = 2'd0,
      OP_TICK       = 2'd1,
      OP_CANCEL     = 2'd2,
      OP_CANCEL_ALL = 2'd3
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [31:0] now_ms;
      logic [3:0]  channel;
      logic [7:0]  target_level;
      logic [15:0] fade_tenths;
      logic        use_cue_fade;
      logic [15:0] delay_tenths;
      logic [31:0] cue_fade_ms;
   } req_type;

   typedef struct packed {
      logic       update_valid;
      logic [3:0] out_channel;
      logic [7:0] level;
      logic       fading;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic act;
      logic check;
      logic capture;
      logic retire;
      logic mul;
      logic div_step;
      logic interp;
      logic idx_inc;
      logic out_upd;
      logic out_status;
   } cmd_type;

   typedef struct packed {
      op_type opcode;
      logic   hit;
      logic   started;
      logic   retire_now;
      logic   idx_last;
      logic   div_last;
      logic   buf_more;
      logic   out_free;
   } sts_type;

   function automatic logic chan_ok(input logic [3:0] ch);
      return int'(ch) < NUM_CHANNELS;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/dlf_ctrl.sv
`default_nettype none
module dlf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dlf_pkg::sts_type sts,
   output dlf_pkg::cmd_type      cmd
);
   import dlf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ACT, S_CHECK, S_EVAL, S_DIV, S_INTERP, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            if (sts.opcode == OP_TICK) begin
               state_in = S_CHECK;
            end else begin
               cmd.act  = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.hit) begin
               cmd.capture = !sts.started;
               state_in    = S_EVAL;
            end else if (sts.idx_last) begin
               state_in = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_EVAL: begin
            if (sts.retire_now) begin
               cmd.retire = 1'b1;
               if (sts.idx_last) begin
                  state_in = S_EMIT;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_CHECK;
               end
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_INTERP;
         end
         S_INTERP: begin
            cmd.interp = 1'b1;
            if (sts.idx_last) begin
               state_in = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               if (sts.buf_more) begin
                  cmd.out_upd = 1'b1;
               end else begin
                  cmd.out_status = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "assert_macros.svh"
   `DLF_ASSERT_NEXT(a_load_acts, clock, reset, cmd.load, state_ff == S_ACT)
   `DLF_ASSERT_NOW(a_out_free, clock, reset, cmd.out_upd || cmd.out_status, sts.out_free)
   `DLF_ASSERT_NEXT(a_status_idle, clock, reset, cmd.out_status, req_ready)

endmodule
`default_nettype wire

FILE: hdl/dlf_dp.sv
`default_nettype none
module dlf_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dlf_pkg::req_type req_payload,
   input  wire dlf_pkg::cmd_type cmd,
   output dlf_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dlf_pkg::rsp_type      rsp_payload
);
   import dlf_pkg::*;

   req_type           req_ff, req_in;
   logic              active_ff   [NUM_SLOTS], active_in   [NUM_SLOTS];
   logic              started_ff  [NUM_SLOTS], started_in  [NUM_SLOTS];
   logic [3:0]        sch_ff      [NUM_SLOTS], sch_in      [NUM_SLOTS];
   logic [7:0]        stgt_ff     [NUM_SLOTS], stgt_in     [NUM_SLOTS];
   logic [7:0]        sfrom_ff    [NUM_SLOTS], sfrom_in    [NUM_SLOTS];
   logic [31:0]       sstart_ff   [NUM_SLOTS], sstart_in   [NUM_SLOTS];
   logic [31:0]       sdur_ff     [NUM_SLOTS], sdur_in     [NUM_SLOTS];
   logic [7:0]        level_ff    [NUM_CHANNELS], level_in [NUM_CHANNELS];
   logic [3:0]        buf_ch_ff   [NUM_SLOTS], buf_ch_in   [NUM_SLOTS];
   logic [7:0]        buf_lvl_ff  [NUM_SLOTS], buf_lvl_in  [NUM_SLOTS];
   logic [CNT_W-1:0]  n_ff, n_in, rd_ff, rd_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-2:0]  dsr_ff, dsr_in;
   logic [7:0]        q_ff, q_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [31:0] elapsed_c, fade_ms, delay_ms;
   logic [7:0]  mag, from_v, to_v, lvl_c;
   logic        push_en, any, found;
   logic [3:0]  push_ch;
   logic [7:0]  push_lvl;

   always_comb begin
      any = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) any = any | active_ff[i];
   end

   assign elapsed_c = req_ff.now_ms - sstart_ff[idx_ff];
   assign fade_ms   = req_ff.use_cue_fade ? req_ff.cue_fade_ms
                                          : 32'(req_ff.fade_tenths) * 32'(MS_PER_TENTH);
   assign delay_ms  = 32'(req_ff.delay_tenths) * 32'(MS_PER_TENTH);
   assign from_v    = sfrom_ff[idx_ff];
   assign to_v      = stgt_ff[idx_ff];
   assign mag       = (to_v >= from_v) ? (to_v - from_v) : (from_v - to_v);
   assign lvl_c     = (to_v >= from_v) ? (from_v + q_ff) : (from_v - q_ff);

   always_comb begin
      req_in       = req_ff;
      active_in    = active_ff;
      started_in   = started_ff;
      sch_in       = sch_ff;
      stgt_in      = stgt_ff;
      sfrom_in     = sfrom_ff;
      sstart_in    = sstart_ff;
      sdur_in      = sdur_ff;
      level_in     = level_ff;
      buf_ch_in    = buf_ch_ff;
      buf_lvl_in   = buf_lvl_ff;
      n_in         = n_ff;
      rd_in        = rd_ff;
      idx_in       = idx_ff;
      elapsed_in   = elapsed_ff;
      num_in       = num_ff;
      dsr_in       = dsr_ff;
      q_in         = q_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      push_en      = 1'b0;
      push_ch      = req_ff.channel;
      push_lvl     = req_ff.target_level;
      found        = 1'b0;

      if (cmd.load) begin
         req_in = req_payload;
         n_in   = '0;
         rd_in  = '0;
         idx_in = '0;
      end

      if (cmd.act) begin
         case (req_ff.opcode)
            OP_LEVEL, OP_CANCEL: begin
               if (chan_ok(req_ff.channel)) begin
                  for (int i = 0; i < NUM_SLOTS; i++)
                     if (active_ff[i] && sch_ff[i] == req_ff.channel) active_in[i] = 1'b0;
                  if (req_ff.opcode == OP_LEVEL) begin
                     if (delay_ms == 32'd0 && fade_ms == 32'd0) begin
                        push_en = 1'b1;
                     end else begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                           if (!found && !active_in[i]) begin
                              found         = 1'b1;
                              active_in[i]  = 1'b1;
                              started_in[i] = 1'b0;
                              sch_in[i]     = req_ff.channel;
                              stgt_in[i]    = req_ff.target_level;
                              sfrom_in[i]   = 8'd0;
                              sstart_in[i]  = req_ff.now_ms + delay_ms;
                              sdur_in[i]    = fade_ms;
                           end
                        end
                     end
                  end
               end
            end
            OP_CANCEL_ALL: begin
               for (int i = 0; i < NUM_SLOTS; i++) active_in[i] = 1'b0;
            end
            default: ;
         endcase
      end

      if (cmd.check) elapsed_in = elapsed_c;

      if (cmd.capture) begin
         started_in[idx_ff] = 1'b1;
         sfrom_in[idx_ff]   = chan_ok(sch_ff[idx_ff]) ? level_ff[sch_ff[idx_ff]] : 8'd0;
      end

      if (cmd.retire) begin
         active_in[idx_ff] = 1'b0;
         push_en           = 1'b1;
         push_ch           = sch_ff[idx_ff];
         push_lvl          = to_v;
      end

      if (cmd.mul) begin
         num_in  = NUM_W'(mag) * NUM_W'(elapsed_ff);
         dsr_in  = {sdur_ff[idx_ff], 7'd0};
         q_in    = '0;
         dcnt_in = '0;
      end

      if (cmd.div_step) begin
         if (num_ff >= {1'b0, dsr_ff}) begin
            num_in = num_ff - {1'b0, dsr_ff};
            q_in   = {q_ff[6:0], 1'b1};
         end else begin
            q_in = {q_ff[6:0], 1'b0};
         end
         dsr_in  = dsr_ff >> 1;
         dcnt_in = dcnt_ff + 1'b1;
      end

      if (cmd.interp) begin
         push_en  = 1'b1;
         push_ch  = sch_ff[idx_ff];
         push_lvl = lvl_c;
      end

      if (push_en) begin
         buf_ch_in[n_ff[IDX_W-1:0]]  = push_ch;
         buf_lvl_in[n_ff[IDX_W-1:0]] = push_lvl;
         n_in                        = n_ff + 1'b1;
         if (chan_ok(push_ch)) level_in[push_ch] = push_lvl;
      end

      if (cmd.idx_inc) idx_in = idx_ff + 1'b1;

      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_upd) begin
         rsp_valid_in        = 1'b1;
         rsp_in.update_valid = 1'b1;
         rsp_in.out_channel  = buf_ch_ff[rd_ff[IDX_W-1:0]];
         rsp_in.level        = buf_lvl_ff[rd_ff[IDX_W-1:0]];
         rsp_in.fading       = any;
         rsp_in.last         = 1'b0;
         rd_in               = rd_ff + 1'b1;
      end else if (cmd.out_status) begin
         rsp_valid_in        = 1'b1;
         rsp_in.update_valid = 1'b0;
         rsp_in.out_channel  = 4'd0;
         rsp_in.level        = 8'd0;
         rsp_in.fading       = any;
         rsp_in.last         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '{default: 1'b0};
         started_ff   <= '{default: 1'b0};
         level_ff     <= '{default: 8'd0};
         n_ff         <= '0;
         rd_ff        <= '0;
         idx_ff       <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         started_ff   <= started_in;
         level_ff     <= level_in;
         n_ff         <= n_in;
         rd_ff        <= rd_in;
         idx_ff       <= idx_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      sch_ff     <= sch_in;
      stgt_ff    <= stgt_in;
      sfrom_ff   <= sfrom_in;
      sstart_ff  <= sstart_in;
      sdur_ff    <= sdur_in;
      buf_ch_ff  <= buf_ch_in;
      buf_lvl_ff <= buf_lvl_in;
      elapsed_ff <= elapsed_in;
      num_ff     <= num_in;
      dsr_ff     <= dsr_in;
      q_ff       <= q_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      sts            = '0;
      sts.opcode     = req_ff.opcode;
      sts.hit        = active_ff[idx_ff] && !elapsed_c[31];
      sts.started    = started_ff[idx_ff];
      sts.retire_now = (sdur_ff[idx_ff] == 32'd0) || (elapsed_ff >= sdur_ff[idx_ff]);
      sts.idx_last   = int'(idx_ff) == NUM_SLOTS - 1;
      sts.div_last   = int'(dcnt_ff) == DIV_STEPS - 1;
      sts.buf_more   = rd_ff < n_ff;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "assert_macros.svh"
   `DLF_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, int'(n_ff) <= NUM_SLOTS)
   `DLF_ASSERT_NOW(a_read_bound, clock, reset, cmd.out_upd, rd_ff < n_ff)
   `DLF_ASSERT_NOW(a_push_room, clock, reset, cmd.retire || cmd.interp, int'(n_ff) < NUM_SLOTS)

endmodule
`default_nettype wire

FILE: hdl/delayed_linear_fade_engine.sv
`default_nettype none
// Fade engine with eight ramp slots and sixteen channel levels, one transaction at a time.
// A level or cancel transaction is acted on and then emits its results; a tick walks
// every slot, only checking an idle or waiting slot, retiring a slot that finishes
// and passing one that interpolates through evaluation, the bit-per-cycle divider and
// interpolation; the results then drain from the output register.
// Results of a tick are buffered and sent after the walk, each carrying the final fading flag,
// then a status result with last set closes every transaction.
module delayed_linear_fade_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dlf_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dlf_pkg::rsp_type      rsp_payload
);
   import dlf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dlf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
